// ===== src/rhist_pkg.sv =====
// ----------------------------------------------------------------------------
// Range histogram package
// Request/response types, register indexes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package rhist_pkg;

  localparam int unsigned CfgIdxW = 4;

  localparam logic [CfgIdxW-1:0] REG_RANGE_LOW  = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_RANGE_HIGH = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_BINS       = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_TRACK      = 4'd3;

  localparam logic [1:0] MODE_ADD     = 2'd0;
  localparam logic [1:0] MODE_ADD_VAL = 2'd1;

  localparam logic [1:0] TRK_NONE    = 2'd0;
  localparam logic [1:0] TRK_SUM     = 2'd1;
  localparam logic [1:0] TRK_HIGHEST = 2'd2;
  localparam logic [1:0] TRK_LOWEST  = 2'd3;

  localparam logic [1:0] REGION_UNDER = 2'd0;
  localparam logic [1:0] REGION_BIN   = 2'd1;
  localparam logic [1:0] REGION_OVER  = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] x_sample;
    logic signed [31:0] y_value;
    logic [7:0]         bin_select;
  } hist_req_t;

  typedef struct packed {
    logic [1:0]         region;
    logic [7:0]         bin_index;
    logic [31:0]        bin_hits;
    logic signed [63:0] bin_data;
    logic [31:0]        total_seen;
    logic [31:0]        under_seen;
    logic [31:0]        over_seen;
    logic signed [31:0] min_sample;
    logic signed [31:0] max_sample;
    logic signed [31:0] mean_sample;
  } hist_rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_STAT,
    ST_IDX,
    ST_RD,
    ST_UPD,
    ST_BDIV,
    ST_MEAN,
    ST_SDIV,
    ST_OUT
  } hist_state_e;

endpackage

`default_nettype wire

// ===== src/range_histogram_with_bin_tracking.sv =====
// ----------------------------------------------------------------------------
// Range histogram with bin tracking
// Histogram over a configurable range with per-bin count and value tracking.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid_i/in_ready_o carry one request (add, add with
//                 value, or read). in_ready_o is high only while the block
//                 is idle; one request is worked on at a time.
//   out channel : out_valid_o/out_ready_i carry one response per request.
//                 The response holds in the output register until taken;
//                 a stalled receiver simply holds the block busy.
//   cfg channel : cfg_valid_i/cfg_ready_o write range_low, range_high,
//                 bins_in_use and track_mode; always ready. Write only while
//                 idle.
//   Timing: a single restoring divider, one quotient bit per cycle, does all
//   division work: the bin index of an in-range add, the bin mean in mean
//   tracking mode and the sample mean, in that order.
//   Reset: statistics clear at once; then a clearing pass writes zero into
//   every bin, with in_ready_o low meanwhile.
`default_nettype none

module range_histogram_with_bin_tracking
  import rhist_pkg::*;
#(
  parameter int unsigned NUM_BINS = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire hist_req_t          in_req_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      hist_rsp_t          out_rsp_o,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);

  localparam int unsigned AW      = $clog2(NUM_BINS);
  localparam int unsigned IdxNumW = 41;   // 9-bit bin count times 32-bit offset

  // configuration
  logic signed [31:0] range_low_q, range_high_q;
  logic [8:0]         bins_q;
  logic [1:0]         track_q;

  // statistics
  logic [31:0]        total_q, under_q, over_q;
  logic signed [63:0] sum_q;
  logic signed [31:0] min_q, max_q;

  // request and response registers
  hist_state_e        state_q, state_d;
  hist_req_t          req_q;
  logic [1:0]         region_q;
  logic [7:0]         idx_out_q;
  logic [31:0]        hits_q;
  logic signed [63:0] data_q;
  logic signed [31:0] mean_q;

  // bin stores
  logic [31:0]        cnt_mem [NUM_BINS];
  logic [63:0]        val_mem [NUM_BINS];
  logic [AW-1:0]      addr_q, clr_q;
  logic [31:0]        rd_cnt_q;
  logic signed [63:0] rd_val_q;

  // shared divider
  logic [63:0]        dnum_q;
  logic [31:0]        drem_q, dvs_q;
  logic [6:0]         dcnt_q;
  logic               dneg_q;
  logic [32:0]        dtrial;
  logic               dqbit;
  logic [63:0]        dres;

  // control decode
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [31:0]        mem_wcnt;
  logic [63:0]        mem_wval;

  // combinational datapath helpers
  logic               is_read, sel_ok, below, above;
  logic signed [63:0] x_ext, y_ext, sum_add, val_add, new_val;
  logic [31:0]        off, span, new_cnt;
  logic [8:0]         bins_eff;
  logic [IdxNumW-1:0] prod;
  logic signed [63:0] mean_full;

  assign cfg_ready_o = 1'b1;

  // --------------------------------------------------------------------------
  // Divider step: shift in one numerator bit, subtract divisor where it fits
  // --------------------------------------------------------------------------
  assign dtrial = {drem_q, dnum_q[63]};
  assign dqbit  = dtrial >= {1'b0, dvs_q};
  assign dres   = dneg_q ? (64'd0 - dnum_q) : dnum_q;

  // --------------------------------------------------------------------------
  // Request decode and arithmetic
  // --------------------------------------------------------------------------
  assign is_read = (req_q.mode != MODE_ADD) && (req_q.mode != MODE_ADD_VAL);
  assign sel_ok  = 32'(req_q.bin_select) < NUM_BINS;
  assign below   = req_q.x_sample < range_low_q;
  assign above   = req_q.x_sample >= range_high_q;
  assign x_ext   = 64'(req_q.x_sample);
  assign y_ext   = 64'(req_q.y_value);
  assign off     = 32'(req_q.x_sample - range_low_q);
  assign span    = 32'(range_high_q - range_low_q);

  always_comb begin
    if (bins_q == 9'd0) begin
      bins_eff = 9'd1;
    end else if (32'(bins_q) > NUM_BINS) begin
      bins_eff = 9'(NUM_BINS);
    end else begin
      bins_eff = bins_q;
    end
  end

  assign prod = IdxNumW'(bins_eff) * IdxNumW'(off);

  // Saturating adds: overflow when operands agree in sign and result does not
  always_comb begin
    sum_add = sum_q + x_ext;
    if ((sum_q[63] == x_ext[63]) && (sum_add[63] != sum_q[63])) begin
      sum_add = sum_q[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    val_add = rd_val_q + y_ext;
    if ((rd_val_q[63] == y_ext[63]) && (val_add[63] != rd_val_q[63])) begin
      val_add = rd_val_q[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
  end

  // New bin contents for an add
  always_comb begin
    new_cnt = (rd_cnt_q == 32'hFFFF_FFFF) ? rd_cnt_q : rd_cnt_q + 32'd1;
    new_val = rd_val_q;
    if (req_q.mode == MODE_ADD_VAL) begin
      case (track_q)
        TRK_SUM: new_val = val_add;
        TRK_HIGHEST: begin
          if ((rd_val_q < y_ext) || (rd_cnt_q == 32'd0)) new_val = y_ext;
        end
        TRK_LOWEST: begin
          if ((rd_val_q > y_ext) || (rd_cnt_q == 32'd0)) new_val = y_ext;
        end
        default: new_val = rd_val_q;
      endcase
    end
  end

  assign mean_full = dres;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (32'(clr_q) == NUM_BINS - 1) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_STAT;
      ST_STAT: begin
        if (is_read) begin
          state_d = sel_ok ? ST_RD : ST_MEAN;
        end else if (below || above) begin
          state_d = ST_MEAN;
        end else begin
          state_d = ST_IDX;
        end
      end
      ST_IDX:   if (dcnt_q == 7'd0) state_d = ST_RD;
      ST_RD:    state_d = ST_UPD;
      ST_UPD: begin
        if ((track_q == TRK_SUM) &&
            ((is_read ? rd_cnt_q : new_cnt) != 32'd0)) begin
          state_d = ST_BDIV;
        end else begin
          state_d = ST_MEAN;
        end
      end
      ST_BDIV:  if (dcnt_q == 7'd0) state_d = ST_MEAN;
      ST_MEAN:  state_d = (total_q != 32'd0) ? ST_SDIV : ST_OUT;
      ST_SDIV:  if (dcnt_q == 7'd0) state_d = ST_OUT;
      ST_OUT:   if (out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control outputs
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = addr_q;
    mem_wcnt    = new_cnt;
    mem_wval    = new_val;
    case (state_q)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_wa   = clr_q;
        mem_wcnt = 32'd0;
        mem_wval = 64'd0;
      end
      ST_IDLE: in_ready_o  = 1'b1;
      ST_UPD:  mem_we      = !is_read;
      ST_OUT:  out_valid_o = 1'b1;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Bin stores
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cnt_mem[mem_wa] <= mem_wcnt;
      val_mem[mem_wa] <= mem_wval;
    end
    if (state_q == ST_RD) begin
      rd_cnt_q <= cnt_mem[addr_q];
      rd_val_q <= val_mem[addr_q];
    end
  end

  // --------------------------------------------------------------------------
  // Control and statistics registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      dcnt_q       <= '0;
      range_low_q  <= '0;
      range_high_q <= '0;
      bins_q       <= 9'(NUM_BINS);
      track_q      <= TRK_NONE;
      total_q      <= '0;
      under_q      <= '0;
      over_q       <= '0;
      sum_q        <= '0;
      min_q        <= '0;
      max_q        <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_RANGE_LOW:  range_low_q  <= cfg_data_i;
          REG_RANGE_HIGH: range_high_q <= cfg_data_i;
          REG_BINS:       bins_q       <= cfg_data_i[8:0];
          REG_TRACK:      track_q      <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      case (state_q)
        ST_CLEAR: clr_q <= clr_q + AW'(1);
        ST_STAT: begin
          if (!is_read) begin
            if ((total_q == 32'd0) || (req_q.x_sample > max_q)) max_q <= req_q.x_sample;
            if ((total_q == 32'd0) || (req_q.x_sample < min_q)) min_q <= req_q.x_sample;
            if (total_q != 32'hFFFF_FFFF) total_q <= total_q + 32'd1;
            sum_q <= sum_add;
            if (below) begin
              if (under_q != 32'hFFFF_FFFF) under_q <= under_q + 32'd1;
            end else if (above) begin
              if (over_q != 32'hFFFF_FFFF) over_q <= over_q + 32'd1;
            end else begin
              dcnt_q <= 7'(IdxNumW);
            end
          end
        end
        ST_UPD:  dcnt_q <= 7'd64;
        ST_MEAN: dcnt_q <= 7'd64;
        ST_IDX, ST_BDIV, ST_SDIV: begin
          if (dcnt_q != 7'd0) dcnt_q <= dcnt_q - 7'd1;
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Request, divider and response datapath
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) req_q <= in_req_i;
      end
      ST_STAT: begin
        region_q  <= REGION_UNDER;
        idx_out_q <= 8'd0;
        hits_q    <= 32'd0;
        data_q    <= 64'sd0;
        if (is_read) begin
          idx_out_q <= req_q.bin_select;
          addr_q    <= AW'(32'(req_q.bin_select));
        end else if (above && !below) begin
          region_q <= REGION_OVER;
        end else if (!below) begin
          region_q <= REGION_BIN;
          // Bin index: quotient of bins*offset by span, left aligned
          dnum_q   <= {prod, 23'd0};
          drem_q   <= 32'd0;
          dvs_q    <= span;
          dneg_q   <= 1'b0;
        end
      end
      ST_IDX, ST_BDIV, ST_SDIV: begin
        if (dcnt_q != 7'd0) begin
          dnum_q <= {dnum_q[62:0], dqbit};
          drem_q <= dqbit ? 32'(dtrial - {1'b0, dvs_q}) : dtrial[31:0];
        end else if (state_q == ST_IDX) begin
          addr_q    <= AW'(dnum_q);
          idx_out_q <= 8'(32'(AW'(dnum_q)));
        end else if (state_q == ST_BDIV) begin
          data_q <= dres;
        end else begin
          if (mean_full > 64'sd2147483647) begin
            mean_q <= 32'sh7FFF_FFFF;
          end else if (mean_full < -64'sd2147483648) begin
            mean_q <= 32'sh8000_0000;
          end else begin
            mean_q <= 32'(mean_full);
          end
        end
      end
      ST_UPD: begin
        hits_q <= is_read ? rd_cnt_q : new_cnt;
        data_q <= is_read ? rd_val_q : new_val;
        // Bin mean: magnitude divide, sign restored afterwards
        dneg_q <= is_read ? rd_val_q[63] : new_val[63];
        dnum_q <= is_read ? (rd_val_q[63] ? 64'd0 - rd_val_q : rd_val_q)
                          : (new_val[63] ? 64'd0 - new_val : new_val);
        drem_q <= 32'd0;
        dvs_q  <= is_read ? rd_cnt_q : new_cnt;
      end
      ST_MEAN: begin
        mean_q <= 32'sd0;
        dneg_q <= sum_q[63];
        dnum_q <= sum_q[63] ? 64'd0 - sum_q : sum_q;
        drem_q <= 32'd0;
        dvs_q  <= total_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_rsp_o.region      = region_q;
    out_rsp_o.bin_index   = idx_out_q;
    out_rsp_o.bin_hits    = hits_q;
    out_rsp_o.bin_data    = data_q;
    out_rsp_o.total_seen  = total_q;
    out_rsp_o.under_seen  = under_q;
    out_rsp_o.over_seen   = over_q;
    out_rsp_o.min_sample  = min_q;
    out_rsp_o.max_sample  = max_q;
    out_rsp_o.mean_sample = mean_q;
  end

`ifndef NO_ASSERTIONS
  a_busy_while_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("accepting while a response is pending");

  a_accept_to_stat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_STAT))
    else $error("accepted request not decoded");

  a_idx_to_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_IDX) && (dcnt_q == 7'd0)) |=> (state_q == ST_RD))
    else $error("bin index done without store read");

  a_no_write_in_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mem_we)
    else $error("store written while idle");
`endif

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Range histogram testbench
// Drives add, add-with-value and read requests through the block under
// several range, bin count and tracking settings, predicts every response
// and compares it as a whole, with random gaps on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import rhist_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NB = 256;
  localparam int unsigned LIMIT = 3_000_000;
  localparam logic [1:0] MODE_READ = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  hist_req_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  hist_rsp_t out_rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always #4 clk = ~clk;

  range_histogram_with_bin_tracking #(.NUM_BINS(NB)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_req_i(in_req),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_rsp_o(out_rsp),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // Predictor state: a private copy of the block's registers and stores
  logic signed [31:0] lo_edge, hi_edge;
  logic [8:0] bin_count_cfg;
  logic [1:0] track_sel;
  logic [31:0] hits_store [NB];
  logic signed [63:0] value_store [NB];
  logic [31:0] n_total, n_under, n_over;
  logic signed [63:0] x_sum;
  logic signed [31:0] x_low, x_high;

  hist_req_t pending_reqs [$];
  hist_rsp_t expected_rsps [$];
  int errors = 0;
  int idle_pct = 0;       // sender gap chance, percent
  int stall_pct = 0;      // receiver stall chance, percent
  int hold_off = 0;       // long receiver hold-off, cycles left
  bit hold_for_drain = 0; // sender waits until all responses are back
  longint cycles = 0;

  function automatic logic [31:0] bump(input logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] bin_value_out(input int i);
    if (track_sel == TRK_SUM) begin
      if (hits_store[i] == 32'd0) return '0;
      return value_store[i] / $signed({32'd0, hits_store[i]});
    end
    return value_store[i];
  endfunction

  // Update the histogram for one request and return the response it causes
  function automatic hist_rsp_t histogram_step(input hist_req_t r);
    hist_rsp_t p;
    logic [63:0] off, span, nb, q;
    int i;
    logic signed [63:0] m;
    p = '0;
    if (r.mode == MODE_ADD || r.mode == MODE_ADD_VAL) begin
      if (n_total == 32'd0) begin
        x_low = r.x_sample;
        x_high = r.x_sample;
      end else begin
        if (r.x_sample > x_high) x_high = r.x_sample;
        if (r.x_sample < x_low) x_low = r.x_sample;
      end
      n_total = bump(n_total);
      x_sum = add_sat(x_sum, 64'(r.x_sample));
      if (r.x_sample < lo_edge) begin
        n_under = bump(n_under);
        p.region = REGION_UNDER;
      end else if (r.x_sample >= hi_edge) begin
        n_over = bump(n_over);
        p.region = REGION_OVER;
      end else begin
        nb = 64'(bin_count_cfg);
        if (nb == 64'd0) nb = 64'd1;
        if (nb > 64'(NB)) nb = 64'(NB);
        off = 64'(64'(r.x_sample) - 64'(lo_edge));
        span = 64'(64'(hi_edge) - 64'(lo_edge));
        q = (nb * off) / span;
        i = (q >= 64'(NB)) ? int'(NB) - 1 : int'(q);
        if (r.mode == MODE_ADD_VAL) begin
          case (track_sel)
            TRK_SUM: value_store[i] = add_sat(value_store[i], 64'(r.y_value));
            TRK_HIGHEST: begin
              if (value_store[i] < r.y_value || hits_store[i] == 32'd0)
                value_store[i] = 64'(r.y_value);
            end
            TRK_LOWEST: begin
              if (value_store[i] > r.y_value || hits_store[i] == 32'd0)
                value_store[i] = 64'(r.y_value);
            end
            default: ;
          endcase
        end
        hits_store[i] = bump(hits_store[i]);
        p.region = REGION_BIN;
        p.bin_index = i[7:0];
        p.bin_hits = hits_store[i];
        p.bin_data = bin_value_out(i);
      end
    end else begin
      p.bin_index = r.bin_select;
      p.bin_hits = hits_store[r.bin_select];
      p.bin_data = bin_value_out(int'(r.bin_select));
    end
    m = '0;
    if (n_total != 32'd0) begin
      m = x_sum / $signed({32'd0, n_total});
      if (m > 64'sd2147483647) m = 64'sd2147483647;
      if (m < -64'sd2147483648) m = -64'sd2147483648;
    end
    p.total_seen = n_total;
    p.under_seen = n_under;
    p.over_seen = n_over;
    p.min_sample = x_low;
    p.max_sample = x_high;
    p.mean_sample = m[31:0];
    return p;
  endfunction

  // Driver: hold each request until it is taken, then advance
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_rsps.push_back(histogram_step(in_req));
        void'(pending_reqs.pop_front());
      end
      if (!(in_valid && !in_ready)) begin
        if (in_valid && in_ready && pending_reqs.size() > 0 && !hold_for_drain
            && $urandom_range(99) >= idle_pct) begin
          in_req <= pending_reqs[0];
        end else if (!in_valid && pending_reqs.size() > 0 && !hold_for_drain
                     && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_req <= pending_reqs[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each taken response with the oldest expectation
  always @(posedge clk) begin
    hist_rsp_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected response %p", $realtime, out_rsp);
          errors <= errors + 1;
        end else begin
          e = expected_rsps.pop_front();
          if (out_rsp !== e) begin
            $display("%0t: mismatch expected %p actual %p", $realtime, e, out_rsp);
            errors <= errors + 1;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Timeout watchdog
  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_RANGE_LOW: lo_edge = val;
      REG_RANGE_HIGH: hi_edge = val;
      REG_BINS: bin_count_cfg = val[8:0];
      REG_TRACK: track_sel = val[1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || in_valid)
      @(posedge clk);
    // let a response still in flight settle before touching registers
    repeat (200) @(posedge clk);
  endtask

  task automatic push(input logic [1:0] md, input logic [31:0] x,
                      input logic [31:0] y, input logic [7:0] sel);
    hist_req_t r;
    r.mode = md;
    r.x_sample = x;
    r.y_value = y;
    r.bin_select = sel;
    pending_reqs.push_back(r);
  endtask

  // Random sample: mostly inside the range, some edges and full-scale noise
  function automatic logic [31:0] pick_x();
    int k;
    logic signed [63:0] lo64, hi64;
    k = $urandom_range(99);
    lo64 = lo_edge;
    hi64 = hi_edge;
    if (k < 70 && hi64 > lo64)
      return 32'(lo64 + 64'($urandom) % (hi64 - lo64));
    if (k < 78) return lo_edge;
    if (k < 84) return hi_edge;
    if (k < 88) return 32'(lo_edge - 1);
    if (k < 91) return 32'h8000_0000;
    if (k < 94) return 32'h7FFF_FFFF;
    return $urandom;
  endfunction

  task automatic random_block(input int n);
    int k;
    logic [1:0] md;
    for (int j = 0; j < n; j++) begin
      k = $urandom_range(99);
      md = (k < 35) ? MODE_ADD : (k < 75) ? MODE_ADD_VAL : (k < 97) ? MODE_READ : MODE_SPARE;
      push(md, pick_x(), ($urandom_range(3) == 0) ? $urandom
                         : 32'($signed($urandom_range(2000)) - 1000),
           ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(15)));
    end
  endtask

  initial begin
    hits_store = '{default: '0};
    value_store = '{default: '0};
    lo_edge = '0; hi_edge = '0; bin_count_cfg = 9'd256; track_sel = TRK_NONE;
    n_total = '0; n_under = '0; n_over = '0; x_sum = '0; x_low = '0; x_high = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty range, reads of cleared bins, extremes of every field
    push(MODE_READ, 32'd0, 32'd0, 8'd0);
    push(MODE_SPARE, 32'd0, 32'd0, 8'd255);
    push(MODE_ADD, 32'h8000_0000, 32'h8000_0000, 8'hFF);
    push(MODE_ADD_VAL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'h00);
    push(MODE_ADD, 32'd0, 32'd0, 8'd0);
    drain();

    // Full-scale range, 256 bins, sum tracking: large sums and saturation edge
    write_reg(REG_RANGE_LOW, 32'h8000_0000);
    write_reg(REG_RANGE_HIGH, 32'h7FFF_FFFF);
    write_reg(REG_BINS, 32'd256);
    write_reg(REG_TRACK, 32'(TRK_SUM));
    push(MODE_ADD_VAL, 32'h8000_0000, 32'h7FFF_FFFF, 8'd0);
    push(MODE_ADD_VAL, 32'h8000_0000, 32'h7FFF_FFFF, 8'd0);
    push(MODE_ADD_VAL, 32'h7FFF_FFFE, 32'h8000_0000, 8'd0);
    push(MODE_ADD_VAL, 32'h7FFF_FFFE, 32'hFFFF_FFFD, 8'd0);
    push(MODE_ADD, 32'h0000_0000, 32'h1234_5678, 8'd0);
    push(MODE_READ, 32'd0, 32'd0, 8'd0);
    push(MODE_READ, 32'd0, 32'd0, 8'd255);
    push(MODE_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd128);
    drain();

    // Max then min tracking on a small range; bins 0 acts as 1, 511 as 256
    write_reg(REG_RANGE_LOW, 32'hFFFF_FFF0);
    write_reg(REG_RANGE_HIGH, 32'd16);
    write_reg(REG_BINS, 32'd0);
    write_reg(REG_TRACK, 32'(TRK_HIGHEST));
    push(MODE_ADD_VAL, 32'hFFFF_FFF0, -32'sd5, 8'd0);
    push(MODE_ADD_VAL, 32'd15, -32'sd9, 8'd0);
    push(MODE_ADD_VAL, 32'd16, 32'd3, 8'd0);
    drain();
    write_reg(REG_BINS, 32'd511);
    write_reg(REG_TRACK, 32'(TRK_LOWEST));
    push(MODE_ADD_VAL, 32'd3, 32'd7, 8'd0);
    push(MODE_ADD_VAL, 32'd3, 32'd9, 8'd0);
    push(MODE_ADD_VAL, 32'd3, -32'sd2, 8'd0);
    push(MODE_READ, 32'd0, 32'd0, 8'd19);
    drain();

    // Random phases: settings from extremes to typical, idling patterns
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 73; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 73; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      write_reg(REG_RANGE_LOW, (ph == 5) ? 32'd100 : 32'($signed($urandom_range(2000)) - 1000));
      write_reg(REG_RANGE_HIGH, (ph == 5) ? 32'd50
                : (ph == 6) ? 32'h7FFF_FFFF : 32'($urandom_range(3000) + 1000));
      write_reg(REG_BINS, (ph == 1) ? 32'd1 : (ph == 3) ? 32'd256
                : 32'($urandom_range(255) + 1));
      write_reg(REG_TRACK, 32'(ph % 4));
      random_block(180);
      if (ph == 2) begin
        // long receiver hold-off while the sender keeps offering
        hold_off = 400;
      end
      if (ph == 4) begin
        // sender pauses until every response is back
        while (pending_reqs.size() > 90) @(posedge clk);
        hold_for_drain = 1;
        while (expected_rsps.size() > 0 || in_valid) @(posedge clk);
        hold_for_drain = 0;
      end
      drain();
    end

    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== range_histogram_with_bin_tracking.f =====
src/rhist_pkg.sv
src/range_histogram_with_bin_tracking.sv
test/testbench.sv
